>>> rtl/core/hsi_pkg.sv
`default_nettype none

package hsi_pkg;

   localparam int CAPTURE_LIMIT_DEFAULT = 511;
   localparam int MAX_DIGITS_DEFAULT    = 15;

   localparam int LENGTH_WIDTH    = 50;
   localparam int THRESHOLD_WIDTH = 32;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam int WINDOW_LEN = 10;
   localparam int POST_LEN   = 5;
   localparam int HEADER_LEN = 8;

   localparam logic [THRESHOLD_WIDTH-1:0] THRESHOLD_RESET = 32'd4096;
   localparam logic [2:0]                 SKIP_START      = 3'd7;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ENABLE    = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_THRESHOLD = 8'd1;

   localparam logic [7:0] POST_PATTERN [POST_LEN] = '{"P", "O", "S", "T", " "};
   localparam logic [7:0] HEADER_PATTERN [HEADER_LEN] =
      '{"C", "o", "n", "t", "e", "n", "t", "-"};
   localparam logic [7:0] PATH_PATTERN [WINDOW_LEN] =
      '{"/", "d", "n", "s", "-", "q", "u", "e", "r", "y"};

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_segment;
   } req_type;

   typedef struct packed {
      logic                    post_request;
      logic                    length_found;
      logic [LENGTH_WIDTH-1:0] content_length;
      logic                    large_post_alert;
      logic                    doh_path_alert;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/core/http_stream_inspector.sv
`default_nettype none

// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_stall  req_data  (req_type)
// rsp      out        rsp_valid / rsp_stall  rsp_data  (rsp_type)
// csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// One byte per cycle while req_stall is low; an end-of-segment byte goes through
// the input and result registers to rsp_valid. The per-byte loop is the ten-byte
// window compare and the 50-bit shift-and-add digit accumulator.
// Reset is synchronous and clears all segment state at once; no clearing pass.
// A result waiting under rsp_stall holds in its register while bytes without an
// end mark keep flowing; only a second end mark stalls the request side.

module http_stream_inspector
   import hsi_pkg::*;
#(
   parameter int CAPTURE_LIMIT = CAPTURE_LIMIT_DEFAULT,
   parameter int MAX_DIGITS    = MAX_DIGITS_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire req_type                    req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output rsp_type                         rsp_data,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   localparam int COUNT_WIDTH = $clog2(CAPTURE_LIMIT + 1);
   localparam int DIGIT_WIDTH = $clog2(MAX_DIGITS + 1);
   localparam logic [COUNT_WIDTH-1:0] LIMIT = COUNT_WIDTH'(CAPTURE_LIMIT);
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_LIMIT = DIGIT_WIDTH'(MAX_DIGITS);
   localparam logic [COUNT_WIDTH-1:0] POST_COUNT = COUNT_WIDTH'(POST_LEN);

   // Configuration registers.
   logic                       enable_ff, enable_in;
   logic [THRESHOLD_WIDTH-1:0] threshold_ff, threshold_in;

   // Input register.
   logic    in_valid_ff, in_valid_in;
   req_type in_ff, in_in;

   // Segment state.
   logic [COUNT_WIDTH-1:0]  byte_count_ff, byte_count_in;
   logic [7:0]              recent_ff [WINDOW_LEN];
   logic [7:0]              recent_in [WINDOW_LEN];
   logic                    prefix_ff, prefix_in;
   logic                    header_ff, header_in;
   logic [2:0]              skip_ff, skip_in;
   logic                    digit_mode_ff, digit_mode_in;
   logic [DIGIT_WIDTH-1:0]  digit_count_ff, digit_count_in;
   logic [LENGTH_WIDTH-1:0] length_ff, length_in;
   logic                    path_ff, path_in;

   // Result register holds the raw findings; alerts are qualified at the port.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    res_post_ff, res_post_in;
   logic                    res_found_ff, res_found_in;
   logic [LENGTH_WIDTH-1:0] res_length_ff, res_length_in;
   logic                    res_path_ff, res_path_in;

   logic req_accept;
   logic in_fire;
   logic rsp_load;

   assign in_fire    = in_valid_ff && !(in_ff.end_of_segment && rsp_valid_ff && rsp_stall);
   assign req_stall  = in_valid_ff && !in_fire;
   assign req_accept = req_valid && !req_stall;
   assign rsp_load   = in_fire && in_ff.end_of_segment;
   assign csr_ready  = 1'b1;

   always_comb begin
      enable_in    = enable_ff;
      threshold_in = threshold_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ENABLE:    enable_in    = csr_data[0];
            CSR_THRESHOLD: threshold_in = csr_data[THRESHOLD_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      in_valid_in = req_accept || (in_valid_ff && !in_fire);
      in_in       = req_accept ? req_data : in_ff;
   end

   // Per-byte update of the segment state.
   always_comb begin
      logic [7:0]              b;
      logic                    take;
      logic                    hdr_match;
      logic                    path_match;
      logic                    is_digit;
      logic [LENGTH_WIDTH-1:0] digit_value;

      b           = in_ff.data_byte;
      take        = in_fire && (byte_count_ff < LIMIT);
      digit_value = LENGTH_WIDTH'(b - "0");
      hdr_match   = 1'b0;
      path_match  = 1'b0;
      is_digit    = 1'b0;

      byte_count_in  = byte_count_ff;
      prefix_in      = prefix_ff;
      header_in      = header_ff;
      skip_in        = skip_ff;
      digit_mode_in  = digit_mode_ff;
      digit_count_in = digit_count_ff;
      length_in      = length_ff;
      path_in        = path_ff;
      for (int i = 0; i < WINDOW_LEN; i++) begin
         recent_in[i] = recent_ff[i];
      end

      if (take) begin
         for (int i = 0; i < WINDOW_LEN - 1; i++) begin
            recent_in[i] = recent_ff[i+1];
         end
         recent_in[WINDOW_LEN-1] = b;
         byte_count_in = byte_count_ff + 1'b1;

         if (byte_count_ff < POST_COUNT && b != POST_PATTERN[byte_count_ff[2:0]]) begin
            prefix_in = 1'b0;
         end

         hdr_match = (b inside {"L", "l"});
         for (int i = 0; i < HEADER_LEN; i++) begin
            if (recent_in[i+1] != HEADER_PATTERN[i]) begin
               hdr_match = 1'b0;
            end
         end

         path_match = 1'b1;
         for (int i = 0; i < WINDOW_LEN; i++) begin
            if (recent_in[i] != PATH_PATTERN[i]) begin
               path_match = 1'b0;
            end
         end

         is_digit = (b inside {["0":"9"]});
         if (digit_mode_ff) begin
            if (is_digit && digit_count_ff < DIGIT_LIMIT) begin
               length_in      = (length_ff << 3) + (length_ff << 1) + digit_value;
               digit_count_in = digit_count_ff + 1'b1;
            end else begin
               digit_mode_in = 1'b0;
            end
         end else if (skip_ff != 3'd0) begin
            skip_in = skip_ff - 3'd1;
            if (skip_ff == 3'd1) begin
               digit_mode_in = 1'b1;
            end
         end else if (!header_ff && hdr_match) begin
            header_in = 1'b1;
            skip_in   = SKIP_START;
         end

         if (path_match) begin
            path_in = 1'b1;
         end
      end

      res_post_in   = res_post_ff;
      res_found_in  = res_found_ff;
      res_length_in = res_length_ff;
      res_path_in   = res_path_ff;
      if (rsp_load) begin
         res_post_in   = prefix_in && (byte_count_in >= POST_COUNT);
         res_found_in  = (digit_count_in != '0);
         res_length_in = (digit_count_in != '0) ? length_in : '0;
         res_path_in   = path_in;

         // The segment ends here, so the next byte starts from a clean slate.
         byte_count_in  = '0;
         prefix_in      = 1'b1;
         header_in      = 1'b0;
         skip_in        = 3'd0;
         digit_mode_in  = 1'b0;
         digit_count_in = '0;
         length_in      = '0;
         path_in        = 1'b0;
         for (int i = 0; i < WINDOW_LEN; i++) begin
            recent_in[i] = 8'd0;
         end
      end

      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff      <= 1'b0;
         threshold_ff   <= THRESHOLD_RESET;
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         byte_count_ff  <= '0;
         prefix_ff      <= 1'b1;
         header_ff      <= 1'b0;
         skip_ff        <= 3'd0;
         digit_mode_ff  <= 1'b0;
         digit_count_ff <= '0;
         length_ff      <= '0;
         path_ff        <= 1'b0;
         for (int i = 0; i < WINDOW_LEN; i++) begin
            recent_ff[i] <= 8'd0;
         end
      end else begin
         enable_ff      <= enable_in;
         threshold_ff   <= threshold_in;
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         byte_count_ff  <= byte_count_in;
         prefix_ff      <= prefix_in;
         header_ff      <= header_in;
         skip_ff        <= skip_in;
         digit_mode_ff  <= digit_mode_in;
         digit_count_ff <= digit_count_in;
         length_ff      <= length_in;
         path_ff        <= path_in;
         for (int i = 0; i < WINDOW_LEN; i++) begin
            recent_ff[i] <= recent_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      in_ff         <= in_in;
      res_post_ff   <= res_post_in;
      res_found_ff  <= res_found_in;
      res_length_ff <= res_length_in;
      res_path_ff   <= res_path_in;
   end

   // The user must change configuration only while idle (the block does not enforce it), so qualifying here is safe.
   always_comb begin
      rsp_valid                 = rsp_valid_ff;
      rsp_data.post_request     = res_post_ff;
      rsp_data.length_found     = res_found_ff;
      rsp_data.content_length   = res_length_ff;
      rsp_data.large_post_alert = enable_ff && res_post_ff && res_found_ff &&
                                  (res_length_ff > LENGTH_WIDTH'(threshold_ff));
      rsp_data.doh_path_alert   = enable_ff && res_path_ff;
   end

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(rsp_load))
      else $error("result appeared without an end-of-segment byte");

   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && in_ff.end_of_segment && rsp_valid_ff && rsp_stall))
      else $error("request side stalled without a blocked result");

   assert property (@(posedge clock) disable iff (reset)
      digit_count_ff <= DIGIT_LIMIT && byte_count_ff <= LIMIT)
      else $error("digit or byte counter past its limit");

   assert property (@(posedge clock) disable iff (reset)
      (digit_mode_ff || skip_ff != 3'd0) |-> header_ff)
      else $error("digit parsing active without a header");

   assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (byte_count_ff == '0 && prefix_ff && !path_ff))
      else $error("segment state not cleared after a result");

endmodule

`default_nettype wire
